// ===== rtl/ssdf_pkg.sv =====
package ssdf_pkg;

	typedef enum logic [1:0] {
		STATUS_PAYLOAD  = 2'd0,
		STATUS_TOO_MANY = 2'd1,
		STATUS_EMPTY    = 2'd2
	} status_t;

	localparam int BYTE_W = 8;
	localparam int SEG_OUT_W = 4;
	localparam int WORD_W = 32;
	localparam int LEFT_W = 35;

	typedef struct packed {
		logic [BYTE_W-1:0]    data;
		logic [SEG_OUT_W-1:0] seg;
		logic                 los;
		logic                 lof;
		status_t              status;
	} result_t;

endpackage

// ===== rtl/ssdf_size_mem.sv =====
module ssdf_size_mem #(
	parameter int MAX_SEGMENTS = 16,
	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [IDX_W-1:0]           waddr,
	input  logic [ssdf_pkg::WORD_W-1:0] wdata,
	input  logic                       re,
	input  logic [IDX_W-1:0]           raddr,
	output logic [ssdf_pkg::WORD_W-1:0] rdata_q
);
	import ssdf_pkg::*;

	logic [WORD_W-1:0] mem [MAX_SEGMENTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ssdf_parser.sv =====
module ssdf_parser #(
	parameter int MAX_SEGMENTS = 16,
	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
	localparam int TOT_W = $clog2(MAX_SEGMENTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  logic [ssdf_pkg::BYTE_W-1:0] in_byte,
	output logic                        mem_we,
	output logic [IDX_W-1:0]            mem_waddr,
	output logic [ssdf_pkg::WORD_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [IDX_W-1:0]            mem_raddr,
	input  logic [ssdf_pkg::WORD_W-1:0] mem_rdata,
	output logic                        res_valid,
	output ssdf_pkg::result_t           res
);
	import ssdf_pkg::*;

	typedef enum logic [1:0] {
		PH_COUNT = 2'd0,
		PH_SIZES = 2'd1,
		PH_PAD   = 2'd2,
		PH_DATA  = 2'd3
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [1:0]         cnt_q, cnt_d;
	logic [23:0]        word_q;
	logic [TOT_W-1:0]   total_q, total_d;
	logic [TOT_W-1:0]   size_idx_q, size_idx_d;
	logic [IDX_W-1:0]   cur_q, cur_d;
	logic [LEFT_W-1:0]  left_q, left_d;
	logic [WORD_W-1:0]  first_size_q;
	logic [WORD_W-1:0]  word;
	logic               word_done;
	logic               seg_end;
	logic               last_size;

	assign word = {in_byte, word_q};
	assign word_done = (cnt_q == 2'd3);
	assign seg_end = (left_q == LEFT_W'(1));
	assign last_size = ((size_idx_q + TOT_W'(1)) == total_q);

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		total_d = total_q;
		size_idx_d = size_idx_q;
		cur_d = cur_q;
		left_d = left_q;
		mem_we = 1'b0;
		mem_waddr = size_idx_q[IDX_W-1:0];
		mem_wdata = word;
		mem_re = 1'b0;
		mem_raddr = IDX_W'(1);
		res_valid = 1'b0;
		res = '0;
		if (acc) begin
			case (phase_q)
				PH_COUNT: begin
					cnt_d = cnt_q + 2'd1;
					if (word_done) begin
						if (word >= WORD_W'(MAX_SEGMENTS)) begin
							res_valid = 1'b1;
							res.status = STATUS_TOO_MANY;
						end else begin
							total_d = TOT_W'(word + 32'd1);
							size_idx_d = '0;
							phase_d = PH_SIZES;
						end
					end
				end
				PH_SIZES: begin
					cnt_d = cnt_q + 2'd1;
					if (word_done) begin
						if (word == '0) begin
							res_valid = 1'b1;
							res.status = STATUS_EMPTY;
							phase_d = PH_COUNT;
						end else begin
							mem_we = 1'b1;
							size_idx_d = size_idx_q + TOT_W'(1);
							if (last_size) begin
								if (!total_q[0]) begin
									phase_d = PH_PAD;
								end else begin
									// odd segment count, no pad: segment 0 size is this word if it is the only size, else the first stored size
									phase_d = PH_DATA;
									cur_d = '0;
									mem_re = 1'b1;
									left_d = (size_idx_q == '0) ? {word, 3'b000}
										: {first_size_q, 3'b000};
								end
							end
						end
					end
				end
				PH_PAD: begin
					cnt_d = cnt_q + 2'd1;
					if (word_done) begin
						phase_d = PH_DATA;
						cur_d = '0;
						mem_re = 1'b1;
						left_d = {first_size_q, 3'b000};
					end
				end
				default: begin
					res_valid = 1'b1;
					res.data = in_byte;
					res.seg = SEG_OUT_W'(cur_q);
					res.status = STATUS_PAYLOAD;
					left_d = left_q - LEFT_W'(1);
					if (seg_end) begin
						res.los = 1'b1;
						if ((TOT_W'(cur_q) + TOT_W'(1)) >= total_q) begin
							res.lof = 1'b1;
							phase_d = PH_COUNT;
							cnt_d = '0;
						end else begin
							// next size was prefetched when this segment began
							cur_d = cur_q + IDX_W'(1);
							left_d = {mem_rdata, 3'b000};
							mem_re = 1'b1;
							mem_raddr = cur_q + IDX_W'(2);
						end
					end
				end
			endcase
			if (res_valid && res.status != STATUS_PAYLOAD) begin
				phase_d = PH_COUNT;
				cnt_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			cnt_q <= '0;
			total_q <= '0;
			size_idx_q <= '0;
			cur_q <= '0;
			left_q <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			total_q <= total_d;
			size_idx_q <= size_idx_d;
			cur_q <= cur_d;
			left_q <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && phase_q != PH_DATA && !word_done) begin
			word_q[{cnt_q, 3'b000} +: 8] <= in_byte;
		end
		if (mem_we && size_idx_q == '0) begin
			first_size_q <= word;
		end
	end

	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("payload phase with no bytes left");

	a_data_seg: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> TOT_W'(cur_q) < total_q)
		else $error("segment index beyond frame");

	a_err_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != STATUS_PAYLOAD |=> phase_q == PH_COUNT && cnt_q == '0)
		else $error("error item without frame restart");

endmodule

// ===== rtl/ssdf_out_skid.sv =====
module ssdf_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  ssdf_pkg::result_t res,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output ssdf_pkg::result_t out_res
);
	import ssdf_pkg::*;

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    take;

	assign take = out_v_q && !out_stall;
	assign in_stall = skid_v_q;
	assign out_valid = out_v_q;
	assign out_res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= res_valid;
		end else if (res_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || take) begin
			if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds an item ahead of the output");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !skid_v_q)
		else $error("item produced while buffer full");

endmodule

// ===== rtl/segment_stream_deframer.sv =====
// channel | signals                                 | flow
// input   | in_valid, in_stall, in_byte             | framed byte stream in
// output  | out_valid, out_stall, out_byte,         | payload bytes and errors out
//         | segment_index, last_of_segment,         |
//         | last_of_frame, status                   |
//
// one byte accepted per cycle in every phase, header and payload alike, while in_stall is low
// the size memory read port prefetches the next segment size when a segment begins
// reset clears control only; the size memory needs no clearing pass
// a two-entry output buffer raises in_stall only when both entries are held
module segment_stream_deframer #(
	parameter int MAX_SEGMENTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [3:0] segment_index,
	output logic       last_of_segment,
	output logic       last_of_frame,
	output logic [1:0] status
);
	import ssdf_pkg::*;

	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	logic              acc;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic [WORD_W-1:0] mem_rdata;
	logic              res_valid;
	result_t           res;
	result_t           out_res;

	assign acc = in_valid && !in_stall;

	ssdf_size_mem #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	ssdf_parser #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.in_byte   (in_byte),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res       (res)
	);

	ssdf_out_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign out_byte = out_res.data;
	assign segment_index = out_res.seg;
	assign last_of_segment = out_res.los;
	assign last_of_frame = out_res.lof;
	assign status = out_res.status;

endmodule
